// ===== src/signed_angle_between_vectors_defines.svh =====
// ---------------------------------------------------------------------------
// Signed angle between vectors: assertion macros
// Shared concurrent assertion forms for the pipeline checks.
// ---------------------------------------------------------------------------
`ifndef SIGNED_ANGLE_BETWEEN_VECTORS_DEFINES_SVH
`define SIGNED_ANGLE_BETWEEN_VECTORS_DEFINES_SVH
// implication checked every clock outside reset
`define SABV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define SABV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/sabv_pkg.sv =====
// ---------------------------------------------------------------------------
// Signed angle between vectors: package
// Widths, CORDIC table and register address.
// ---------------------------------------------------------------------------
`default_nettype none
package sabv_pkg;
   localparam int COMPONENT_BITS  = 16;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int ANGLE_BITS      = 17;
   localparam int ATAN_FRAC       = 16;
   localparam int CORDIC_STEPS    = 20;
   localparam int CORDIC_W        = 34;
   localparam int Z_W             = 26;
   localparam int ADDR_BITS       = 2;
   localparam logic [ADDR_BITS-1:0] REG_MIN_DENOM = 2'd0;

   function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
      logic signed [Z_W-1:0] r;
      begin
         case (i)
            5'd0: r = 26'sd2949120;   5'd1: r = 26'sd1740967;
            5'd2: r = 26'sd919879;    5'd3: r = 26'sd466945;
            5'd4: r = 26'sd234379;    5'd5: r = 26'sd117304;
            5'd6: r = 26'sd58666;     5'd7: r = 26'sd29335;
            5'd8: r = 26'sd14668;     5'd9: r = 26'sd7334;
            5'd10: r = 26'sd3667;     5'd11: r = 26'sd1833;
            5'd12: r = 26'sd917;      5'd13: r = 26'sd458;
            5'd14: r = 26'sd229;      5'd15: r = 26'sd115;
            5'd16: r = 26'sd57;       5'd17: r = 26'sd29;
            5'd18: r = 26'sd14;       5'd19: r = 26'sd7;
            default: r = '0;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

// ===== src/signed_angle_between_vectors.sv =====
// ---------------------------------------------------------------------------
// Signed angle between vectors
// Usage: drive req_valid with nine vector components; each accepted item
// yields one rsp item carrying angle_deg (degrees, 8 fraction bits) and
// degenerate. An item is accepted when valid is high and stall low.
// Throughput: one item per cycle while no rsp stall holds the pipeline.
// An item passes the magnitude square root (64 stages), the 2-bit divider
// (31 stages), the sine square root (31 stages) and 20 CORDIC stages, plus
// input stages and the stages that join them, before it is offered on rsp.
// A receiver stall on a valid rsp item freezes the whole pipeline;
// req_stall follows it, so nothing is lost or repeated. Reset clears all
// valid bits and sets min_denominator to 1. csr_ is an APB-style port with
// one register at 0.
// ---------------------------------------------------------------------------
`default_nettype none
module signed_angle_between_vectors #(
   parameter int COMPONENT_BITS  = sabv_pkg::COMPONENT_BITS,
   parameter int ANGLE_FRAC_BITS = sabv_pkg::ANGLE_FRAC_BITS
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire signed [COMPONENT_BITS-1:0] req_from_x, req_from_y, req_from_z,
   input  wire signed [COMPONENT_BITS-1:0] req_to_x, req_to_y, req_to_z,
   input  wire signed [COMPONENT_BITS-1:0] req_axis_x, req_axis_y, req_axis_z,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic signed [16:0]              rsp_angle_deg,
   output logic                            rsp_degenerate,
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire [sabv_pkg::ADDR_BITS-1:0]   csr_paddr,
   input  wire [31:0]                      csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
`include "signed_angle_between_vectors_defines.svh"
   logic [31:0] min_denom_ff;
   logic        adv;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == sabv_pkg::REG_MIN_DENOM) ? min_denom_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_denom_ff <= 32'd1;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == sabv_pkg::REG_MIN_DENOM) begin
         min_denom_ff <= csr_pwdata;
      end
   end

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   sabv_core #(.COMPONENT_BITS(COMPONENT_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_core (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_valid),
      .f_x(req_from_x), .f_y(req_from_y), .f_z(req_from_z),
      .t_x(req_to_x), .t_y(req_to_y), .t_z(req_to_z),
      .a_x(req_axis_x), .a_y(req_axis_y), .a_z(req_axis_z),
      .min_denom(min_denom_ff), .out_valid(rsp_valid),
      .out_angle(rsp_angle_deg), .out_degen(rsp_degenerate)
   );

   `SABV_ASSERT_IMP(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate,
      rsp_angle_deg == '0, "degenerate item with nonzero angle")
   `SABV_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_angle_deg), "stalled item changed")
   `SABV_ASSERT_IMP(a_stall_follow, clock, reset, rsp_valid && rsp_stall,
      req_stall, "input not held while output stalls")
endmodule
`default_nettype wire

// ===== src/sabv_core.sv =====
// ---------------------------------------------------------------------------
// Signed angle between vectors: arithmetic pipeline
// Products, square roots, division and CORDIC as one flat register pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
module sabv_core #(
   parameter int COMPONENT_BITS  = sabv_pkg::COMPONENT_BITS,
   parameter int ANGLE_FRAC_BITS = sabv_pkg::ANGLE_FRAC_BITS
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               adv,
   input  wire                               in_valid,
   input  wire signed [COMPONENT_BITS-1:0]   f_x, f_y, f_z, t_x, t_y, t_z, a_x, a_y, a_z,
   input  wire [31:0]                        min_denom,
   output logic                              out_valid,
   output logic signed [sabv_pkg::ANGLE_BITS-1:0] out_angle,
   output logic                              out_degen
);
   localparam int CB  = COMPONENT_BITS;
   localparam int PW  = 2*CB + 2;
   localparam int PPW = 4*CB + 4;
   localparam int SQ  = 2*CB + 2;
   localparam int NS  = 64;
   localparam int DV  = 31;
   localparam int SW  = 31;
   localparam int CS  = sabv_pkg::CORDIC_STEPS;
   localparam int CW  = sabv_pkg::CORDIC_W;
   localparam int ZW  = sabv_pkg::Z_W;
   localparam int L   = 2 + NS + 1 + DV + SW + 1 + CS + 1;
   localparam int C1  = 2 + NS + 1;
   localparam int C2  = C1 + DV;
   localparam int C3  = C2 + SW + 1;
   localparam int C4  = C3 + CS;

   typedef struct packed {
      logic                 deg;
      logic                 neg;
      logic                 tneg;
      logic [PW-1:0]        ud;
      logic [PPW-1:0]       ab;
      logic [SQ+1:0]        d;
      logic [63:0]          q;
      logic [63:0]          qrem;
      logic [31:0]          dd;
      logic [30:0]          c;
      logic [31:0]          s;
      logic [62:0]          srem;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } stg_type;

   logic    v_ff [L+1];
   stg_type s_ff [L+1];
   stg_type s_in [L+1];

   logic signed [2*CB:0] pxx_ff [9];
   logic signed [PW-1:0] dot_ff, aa_ff, bb_ff;
   logic signed [PW+1:0] cx_ff, cy_ff, cz_ff;
   logic signed [CB-1:0] ax_ff, ay_ff, az_ff;
   logic signed [PW+CB+3:0] tp_in;
   logic signed [PW+CB+3:0] tp_ff;
   logic [63:0] msq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pxx_ff[0] <= f_x*t_x; pxx_ff[1] <= f_y*t_y; pxx_ff[2] <= f_z*t_z;
         pxx_ff[3] <= f_x*f_x; pxx_ff[4] <= f_y*f_y; pxx_ff[5] <= f_z*f_z;
         pxx_ff[6] <= t_x*t_x; pxx_ff[7] <= t_y*t_y; pxx_ff[8] <= t_z*t_z;
         cx_ff <= PW'(f_y*t_z) - PW'(f_z*t_y);
         cy_ff <= PW'(f_z*t_x) - PW'(f_x*t_z);
         cz_ff <= PW'(f_x*t_y) - PW'(f_y*t_x);
         ax_ff <= a_x; ay_ff <= a_y; az_ff <= a_z;
         msq_ff <= 64'(min_denom) * 64'(min_denom);
         dot_ff <= PW'(pxx_ff[0]) + PW'(pxx_ff[1]) + PW'(pxx_ff[2]);
         aa_ff  <= PW'(pxx_ff[3]) + PW'(pxx_ff[4]) + PW'(pxx_ff[5]);
         bb_ff  <= PW'(pxx_ff[6]) + PW'(pxx_ff[7]) + PW'(pxx_ff[8]);
         tp_ff  <= tp_in;
      end
   end

   assign tp_in = ax_ff*cx_ff + ay_ff*cy_ff + az_ff*cz_ff;

   always_comb begin
      logic [PPW+1:0] trial;
      logic [PPW-1:0] sh;
      logic [64:0]    t65;
      logic [63:0]    t64;
      logic signed [CW-1:0] dx, dy;
      int k;
      s_in[0] = '0;
      for (int j = 1; j <= L; j++) s_in[j] = s_ff[j-1];
      s_in[2]      = '0;
      s_in[2].neg  = dot_ff[PW-1];
      s_in[2].ud   = dot_ff[PW-1] ? PW'(-dot_ff) : PW'(dot_ff);
      s_in[2].ab   = PPW'($unsigned(aa_ff)) * PPW'($unsigned(bb_ff));
      s_in[2].tneg = tp_ff[PW+CB+3];
      s_in[2].d    = '0;
      s_in[2].deg  = 1'b0;
      for (int j = 3; j < 3 + NS; j++) begin
         k = NS - 1 - (j - 3);
         trial = {s_ff[j-1].d, 2'b01} << (2*k);
         sh = s_ff[j-1].ab;
         if (k*2 < PPW + 2 && trial <= {2'b00, sh}) begin
            s_in[j].ab = sh - PPW'(trial);
            s_in[j].d  = {s_ff[j-1].d[SQ:0], 1'b1};
         end else begin
            s_in[j].d  = {s_ff[j-1].d[SQ:0], 1'b0};
         end
      end
      s_in[3].deg = (s_ff[2].ab < PPW'(msq_ff));
      s_in[C1].dd = 32'(s_ff[C1-1].d);
      s_in[C1].qrem = 64'(s_ff[C1-1].ud) << 30;
      for (int j = 0; j < SQ + 2 - 32; j++)
         if ((s_ff[C1-1].d >> (32 + j)) != '0) begin
            s_in[C1].dd   = 32'(s_ff[C1-1].d >> (j + 1));
            s_in[C1].qrem = 64'(s_ff[C1-1].ud >> (j + 1)) << 30;
         end
      s_in[C1].q = '0;
      for (int j = C1 + 1; j <= C2; j++) begin
         k = C2 - j;
         t65 = {1'b0, s_ff[j-1].qrem} >> (k * 2);
         t64 = 64'(t65);
         s_in[j].q    = s_ff[j-1].q << 2;
         s_in[j].qrem = s_ff[j-1].qrem;
         if (t64 >= 64'(s_ff[j-1].dd) * 3) begin
            s_in[j].q = (s_ff[j-1].q << 2) | 64'd3;
            s_in[j].qrem = s_ff[j-1].qrem - ((64'(s_ff[j-1].dd) * 3) << (k * 2));
         end else if (t64 >= 64'(s_ff[j-1].dd) * 2) begin
            s_in[j].q = (s_ff[j-1].q << 2) | 64'd2;
            s_in[j].qrem = s_ff[j-1].qrem - ((64'(s_ff[j-1].dd) * 2) << (k * 2));
         end else if (t64 >= 64'(s_ff[j-1].dd)) begin
            s_in[j].q = (s_ff[j-1].q << 2) | 64'd1;
            s_in[j].qrem = s_ff[j-1].qrem - (64'(s_ff[j-1].dd) << (k * 2));
         end
      end
      if (s_ff[C2].dd == '0 && s_ff[C2].d == '0) begin
         s_in[C2+1].c   = 31'h4000_0000;
         s_in[C2+1].neg = 1'b1;
      end else begin
         s_in[C2+1].c = (s_ff[C2].q > 64'h4000_0000) ? 31'h4000_0000 : 31'(s_ff[C2].q);
      end
      s_in[C2+1].srem = 63'h1000_0000_0000_0000 - 63'(s_in[C2+1].c) * 63'(s_in[C2+1].c);
      s_in[C2+1].s = '0;
      for (int j = C2 + 2; j <= C3; j++) begin
         k = C3 - j;
         t64 = 64'({s_ff[j-1].s, 2'b01}) << (2 * k);
         if (t64 <= 64'(s_ff[j-1].srem)) begin
            s_in[j].srem = s_ff[j-1].srem - 63'(t64);
            s_in[j].s    = {s_ff[j-1].s[30:0], 1'b1};
         end else begin
            s_in[j].s    = {s_ff[j-1].s[30:0], 1'b0};
         end
      end
      if (s_ff[C3-1].neg && s_ff[C3-1].c != '0) begin
         s_in[C3].x = CW'(s_in[C3].s);
         s_in[C3].y = CW'(s_ff[C3-1].c);
         s_in[C3].z = ZW'(90 <<< 16);
      end else begin
         s_in[C3].x = CW'(s_ff[C3-1].c);
         s_in[C3].y = CW'(s_in[C3].s);
         s_in[C3].z = '0;
      end
      for (int j = C3 + 1; j <= C4; j++) begin
         k = j - C3 - 1;
         dx = s_ff[j-1].y >>> k;
         dy = s_ff[j-1].x >>> k;
         if (s_ff[j-1].y > 0) begin
            s_in[j].x = s_ff[j-1].x + dx; s_in[j].y = s_ff[j-1].y - dy;
            s_in[j].z = s_ff[j-1].z + sabv_pkg::atan_q16(5'(k));
         end else begin
            s_in[j].x = s_ff[j-1].x - dx; s_in[j].y = s_ff[j-1].y + dy;
            s_in[j].z = s_ff[j-1].z - sabv_pkg::atan_q16(5'(k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= L; j++) v_ff[j] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int j = 1; j <= L; j++) v_ff[j] <= v_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j <= L; j++) s_ff[j] <= s_in[j];
      end
   end

   logic signed [ZW-1:0] zc;
   logic [ZW-1:0]        rnd;
   logic signed [sabv_pkg::ANGLE_BITS-1:0] mag;

   always_comb begin
      zc = s_ff[L].z;
      if (zc < 0) zc = '0;
      if (zc > ZW'(180 <<< 16)) zc = ZW'(180 <<< 16);
      if (ANGLE_FRAC_BITS < 16)
         rnd = (ZW'(zc) + (ZW'(1) << (15 - ANGLE_FRAC_BITS))) >> (16 - ANGLE_FRAC_BITS);
      else
         rnd = ZW'(zc) << (ANGLE_FRAC_BITS - 16);
      mag = sabv_pkg::ANGLE_BITS'(rnd);
   end

   assign out_valid = v_ff[L];
   assign out_degen = s_ff[L].deg;
   assign out_angle = s_ff[L].deg ? '0 : (s_ff[L].tneg ? -mag : mag);
endmodule
`default_nettype wire
